// ----- rtl/tcat_pkg.sv -----
`default_nettype none
package tcat_pkg;

   localparam int SAMPLE_W = 10;
   localparam int THRESH_W = 9;
   localparam int CHAR_W   = 8;
   localparam int AVG_W    = 10;
   localparam int CV_W     = 9;
   localparam int DIGIT_W  = 4;
   localparam int REM_W    = 7;

   // centivolts = avg * 330 / 1024
   localparam int CV_SCALE = 330;
   localparam int CV_SHIFT = 10;
   localparam int SCALE_W  = AVG_W + CV_W;

   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

   // character positions within one report
   localparam logic [1:0] POS_UNITS      = 2'd0;
   localparam logic [1:0] POS_TENTHS     = 2'd1;
   localparam logic [1:0] POS_HUNDREDTHS = 2'd2;
   localparam logic [1:0] POS_NEWLINE    = 2'd3;

   typedef struct packed {
      logic fire;
      logic channel;
   } stage_tag_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] units;
      logic [DIGIT_W-1:0] tenths;
      logic [DIGIT_W-1:0] hundredths;
      logic               channel;
      logic               click;
   } report_type;

endpackage
`default_nettype wire

// ----- rtl/tcat_accum.sv -----
`default_nettype none
module tcat_accum #(
   parameter int SAMPLES_PER_AVERAGE = 3,
   parameter int SUM_W = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [tcat_pkg::SAMPLE_W-1:0] in_sample,
   output tcat_pkg::stage_tag_type            out_tag,
   output logic [SUM_W-1:0]                   out_sum
);
   import tcat_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

   logic                 in_v_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic                 next_channel_ff;
   logic [SUM_W-1:0]     sum_ff [2];
   logic [CNT_W-1:0]     cnt_ff [2];
   stage_tag_type        tag_ff;
   logic [SUM_W-1:0]     out_sum_ff;

   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     cnt_in;
   logic                 fire;

   assign sum_in = sum_ff[next_channel_ff] + SUM_W'(sample_ff);
   assign cnt_in = cnt_ff[next_channel_ff] + CNT_W'(1);
   assign fire   = (cnt_in == CNT_W'(SAMPLES_PER_AVERAGE));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff         <= 1'b0;
         next_channel_ff <= 1'b0;
         sum_ff[0]       <= '0;
         sum_ff[1]       <= '0;
         cnt_ff[0]       <= '0;
         cnt_ff[1]       <= '0;
         tag_ff          <= '0;
      end else if (advance) begin
         in_v_ff      <= in_valid;
         tag_ff.fire  <= in_v_ff && fire;
         if (in_v_ff) begin
            tag_ff.channel  <= next_channel_ff;
            next_channel_ff <= ~next_channel_ff;
            // clear the channel once its average goes out
            if (fire) begin
               sum_ff[next_channel_ff] <= '0;
               cnt_ff[next_channel_ff] <= '0;
            end else begin
               sum_ff[next_channel_ff] <= sum_in;
               cnt_ff[next_channel_ff] <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_ff  <= in_sample;
         out_sum_ff <= sum_in;
      end
   end

   assign out_tag = tag_ff;
   assign out_sum = out_sum_ff;

endmodule
`default_nettype wire

// ----- rtl/tcat_conv.sv -----
`default_nettype none
module tcat_conv #(
   parameter int SAMPLES_PER_AVERAGE = 3,
   parameter int SUM_W = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [tcat_pkg::THRESH_W-1:0] threshold,
   input  tcat_pkg::stage_tag_type            in_tag,
   input  wire logic [SUM_W-1:0]              in_sum,
   output logic                               rep_valid,
   output tcat_pkg::report_type               rep
);
   import tcat_pkg::*;

   // floor reciprocal: quotient comes out exact or one short
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / SAMPLES_PER_AVERAGE);

   stage_tag_type       tag1_ff, tag2_ff, tag3_ff;
   logic                rep_v_ff;
   logic [SUM_W-1:0]    sum1_ff;
   logic [AVG_W-1:0]    q0_ff;
   logic [AVG_W-1:0]    avg_ff;
   logic [CV_W-1:0]     cv_ff;
   report_type          rep_ff;

   logic [PROD_W-1:0]   prod;
   logic [SUM_W-1:0]    qm;
   logic [SUM_W-1:0]    rem_sum;
   logic [AVG_W-1:0]    avg_in;
   logic [SCALE_W-1:0]  scaled;
   logic [CV_W-1:0]     cv_rest;
   logic [REM_W-1:0]    rem;
   logic [DIGIT_W-1:0]  units_in;
   logic [DIGIT_W-1:0]  tenths_in;
   logic [REM_W-1:0]    tens_part;
   logic [REM_W-1:0]    hund_rest;

   assign prod    = PROD_W'(in_sum) * PROD_W'(RECIP);
   assign qm      = SUM_W'(q0_ff) * SUM_W'(SAMPLES_PER_AVERAGE);
   assign rem_sum = sum1_ff - qm;
   assign avg_in  = (rem_sum >= SUM_W'(SAMPLES_PER_AVERAGE)) ? q0_ff + AVG_W'(1) : q0_ff;
   assign scaled  = SCALE_W'(avg_ff) * SCALE_W'(CV_SCALE);

   // split centivolts into decimal digits by compares
   always_comb begin
      if (cv_ff >= CV_W'(300)) begin
         units_in = DIGIT_W'(3);
         cv_rest  = cv_ff - CV_W'(300);
      end else if (cv_ff >= CV_W'(200)) begin
         units_in = DIGIT_W'(2);
         cv_rest  = cv_ff - CV_W'(200);
      end else if (cv_ff >= CV_W'(100)) begin
         units_in = DIGIT_W'(1);
         cv_rest  = cv_ff - CV_W'(100);
      end else begin
         units_in = '0;
         cv_rest  = cv_ff;
      end
      rem       = cv_rest[REM_W-1:0];
      tenths_in = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= REM_W'(10 * k)) tenths_in = DIGIT_W'(k);
      end
      tens_part = {tenths_in, 3'b000} + {2'b00, tenths_in, 1'b0};
      hund_rest = rem - tens_part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff  <= '0;
         tag2_ff  <= '0;
         tag3_ff  <= '0;
         rep_v_ff <= 1'b0;
      end else if (advance) begin
         tag1_ff  <= in_tag;
         tag2_ff  <= tag1_ff;
         tag3_ff  <= tag2_ff;
         rep_v_ff <= tag3_ff.fire;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum1_ff           <= in_sum;
         q0_ff             <= prod[SUM_W +: AVG_W];
         avg_ff            <= avg_in;
         cv_ff             <= scaled[CV_SHIFT +: CV_W];
         rep_ff.units      <= units_in;
         rep_ff.tenths     <= tenths_in;
         rep_ff.hundredths <= hund_rest[DIGIT_W-1:0];
         rep_ff.channel    <= tag3_ff.channel;
         rep_ff.click      <= (cv_ff > threshold);
      end
   end

   assign rep_valid = rep_v_ff;
   assign rep       = rep_ff;

endmodule
`default_nettype wire

// ----- rtl/tcat_ser.sv -----
`default_nettype none
module tcat_ser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rep_valid,
   input  tcat_pkg::report_type             rep,
   output logic                             take,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tcat_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_channel,
   output logic                             rsp_click,
   output logic                             rsp_last
);
   import tcat_pkg::*;

   logic        busy_ff;
   logic [1:0]  pos_ff;
   report_type  rep_ff;
   logic        at_last;
   logic        load;

   assign at_last = (pos_ff == POS_NEWLINE);
   assign take    = !busy_ff || (rsp_ready && at_last);
   assign load    = take && rep_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_UNITS;
      end else if (load) begin
         busy_ff <= 1'b1;
         pos_ff  <= POS_UNITS;
      end else if (busy_ff && rsp_ready) begin
         // advance to the next character, drop out after the newline
         if (at_last) busy_ff <= 1'b0;
         pos_ff <= pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rep_ff <= rep;
   end

   always_comb begin
      case (pos_ff)
         POS_UNITS:      rsp_character = ASCII_ZERO + CHAR_W'(rep_ff.units);
         POS_TENTHS:     rsp_character = ASCII_ZERO + CHAR_W'(rep_ff.tenths);
         POS_HUNDREDTHS: rsp_character = ASCII_ZERO + CHAR_W'(rep_ff.hundredths);
         default:        rsp_character = NEWLINE_CHAR;
      endcase
   end

   assign rsp_valid   = busy_ff;
   assign rsp_channel = rep_ff.channel;
   assign rsp_click   = rep_ff.click;
   assign rsp_last    = at_last;

endmodule
`default_nettype wire

// ----- rtl/two_channel_average_threshold_unit.sv -----
// Two-channel averaging voltage reporter.
// req channel: one 10-bit converter word per transfer; words alternate
// between channel 0 and channel 1, channel 0 first after reset.
// Every SAMPLES_PER_AVERAGE words of a channel produce one report on the
// rsp channel: four words, the units, tenths and hundredths digits of the
// averaged voltage as ASCII, then a newline with rsp_last high. rsp_channel
// and rsp_click hold for the whole report; click is high when the value in
// hundredths of a volt exceeds the threshold.
// csr channel: writes the click threshold (reset 150); write only while idle.
// The first character of a report is valid once the word that completes the
// average is accepted and has passed the input register (loaded by the
// accepting edge), accumulate, four conversion stages and output register. A
// word is accepted every cycle while req_ready is high; a report holds the
// output register for all four of its words, so the character serialiser
// sets the sustained rate of completing words.
// Reset clears sums, counts, the channel toggle and all pipeline valids.
// When rsp_ready is low the output holds and the pipeline stalls as a whole
// once a finished report waits behind it; req_ready then drops.
`default_nettype none
module two_channel_average_threshold_unit #(
   parameter int SAMPLES_PER_AVERAGE = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tcat_pkg::SAMPLE_W-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tcat_pkg::CHAR_W-1:0]        rsp_character,
   output logic                               rsp_channel,
   output logic                               rsp_click,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tcat_pkg::THRESH_W-1:0] csr_data
);
   import tcat_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);

   logic [THRESH_W-1:0] threshold_ff;
   logic                advance;
   logic                take;
   logic                rep_valid;
   report_type          rep;
   stage_tag_type       acc_tag;
   logic [SUM_W-1:0]    acc_sum;

   always_ff @(posedge clock) begin
      if (reset) threshold_ff <= THRESH_W'(150);
      else if (csr_valid) threshold_ff <= csr_data;
   end

   assign csr_ready = 1'b1;

   // stall everything only while a finished report cannot move on
   assign advance   = !rep_valid || take;
   assign req_ready = advance;

   tcat_accum #(
      .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
      .SUM_W(SUM_W)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(req_valid),
      .in_sample(req_sample),
      .out_tag(acc_tag),
      .out_sum(acc_sum)
   );

   tcat_conv #(
      .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
      .SUM_W(SUM_W)
   ) u_conv (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .threshold(threshold_ff),
      .in_tag(acc_tag),
      .in_sum(acc_sum),
      .rep_valid(rep_valid),
      .rep(rep)
   );

   tcat_ser u_ser (
      .clock(clock),
      .reset(reset),
      .rep_valid(rep_valid),
      .rep(rep),
      .take(take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_character(rsp_character),
      .rsp_channel(rsp_channel),
      .rsp_click(rsp_click),
      .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

// ----- rtl/tcat_checker.sv -----
`default_nettype none
module tcat_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_character,
   input wire logic       rsp_channel,
   input wire logic       rsp_click,
   input wire logic       rsp_last
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   a_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character == 8'd10)
      else $error("last word is not a newline");

   a_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_character >= 8'd48 && rsp_character <= 8'd57)
      else $error("digit word out of range");

   // a report runs without gaps and keeps its channel and click
   a_report_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && $stable(rsp_channel) && $stable(rsp_click))
      else $error("report broken up");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind two_channel_average_threshold_unit tcat_checker u_tcat_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_character(rsp_character),
   .rsp_channel(rsp_channel),
   .rsp_click(rsp_click),
   .rsp_last(rsp_last)
);
`default_nettype wire

// ----- tb/tb_two_channel_average_threshold_unit.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_two_channel_average_threshold_unit;
   import tcat_pkg::*;

   localparam int AVG_SAMPLES  = 3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 150;
   localparam int PHASES       = 5;
   localparam int GROUPS       = 12;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              channel;
      logic              click;
      logic              last;
   } char_word_type;

   // Running averages per channel and the characters they are due to print.
   class voltage_report_board;
      logic [THRESH_W-1:0] threshold_cv;
      logic                next_chan;
      int unsigned         chan_sum [2];
      int unsigned         chan_count [2];
      char_word_type       expected_chars [$];
      int unsigned         errors;

      function new();
         threshold_cv  = 9'd150;
         next_chan     = 1'b0;
         chan_sum[0]   = 0;
         chan_sum[1]   = 0;
         chan_count[0] = 0;
         chan_count[1] = 0;
         errors        = 0;
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] s);
         int unsigned avg, units, tenths, cv, hundredths;
         logic ch, fire;
         ch = next_chan;
         chan_sum[ch] += s;
         chan_count[ch]++;
         next_chan = ~ch;
         if (chan_count[ch] < AVG_SAMPLES) return;
         avg        = chan_sum[ch] / AVG_SAMPLES;
         units      = (avg * 33) / 10240;
         tenths     = (avg * 33) / 1024 - 10 * units;
         cv         = (avg * 330) / 1024;
         hundredths = cv - 100 * units - 10 * tenths;
         fire       = (cv > threshold_cv);
         expected_chars.push_back('{ASCII_ZERO + CHAR_W'(units), ch, fire, 1'b0});
         expected_chars.push_back('{ASCII_ZERO + CHAR_W'(tenths), ch, fire, 1'b0});
         expected_chars.push_back('{ASCII_ZERO + CHAR_W'(hundredths), ch, fire, 1'b0});
         expected_chars.push_back('{NEWLINE_CHAR, ch, fire, 1'b1});
         chan_sum[ch]   = 0;
         chan_count[ch] = 0;
      endfunction

      function void check_char(char_word_type got);
         char_word_type exp;
         if (expected_chars.size() == 0) begin
            $error("unexpected word: character %0d channel %0d", got.character, got.channel);
            errors++;
            return;
         end
         exp = expected_chars.pop_front();
         if (got.character !== exp.character) begin
            $error("character: expected %0d, got %0d", exp.character, got.character);
            errors++;
         end
         if (got.channel !== exp.channel) begin
            $error("channel: expected %0d, got %0d", exp.channel, got.channel);
            errors++;
         end
         if (got.click !== exp.click) begin
            $error("click: expected %0d, got %0d", exp.click, got.click);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_channel;
   logic                rsp_click;
   logic                rsp_last;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [THRESH_W-1:0] csr_data   = '0;

   voltage_report_board board;
   bit                  req_gaps_on     = 1'b1;
   bit                  rsp_gaps_on     = 1'b1;
   int                  rsp_hold_cycles = 0;
   logic [SAMPLE_W-1:0] directed_words [18];

   two_channel_average_threshold_unit #(
      .SAMPLES_PER_AVERAGE(AVG_SAMPLES)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_channel  (rsp_channel),
      .rsp_click    (rsp_click),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.take_sample(req_sample);
   endtask

   task automatic write_threshold(logic [THRESH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      board.threshold_cv = csr_data;
      csr_valid <= 1'b0;
   endtask

   // Hold until every report is out, then let any part-filled average settle.
   task automatic wait_for_drain();
      while (board.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int            gap;
      char_word_type got;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = rsp_gaps_on ? $urandom_range(0, 6) : 0;
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got = '{rsp_character, rsp_channel, rsp_click, rsp_last};
         board.check_char(got);
      end
   end

   initial begin : stimulus
      int unsigned         thr;
      int unsigned         style;
      int                  near;
      int                  s_val;
      logic [SAMPLE_W-1:0] s;
      board = new();
      // channel 0 on even words: zero / full scale, either side of 150 cv, uneven sums
      directed_words = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023,
                         10'd466, 10'd469, 10'd466, 10'd469, 10'd466, 10'd469,
                         10'd1023, 10'd1022, 10'd1022, 10'd1023, 10'd1022, 10'd512};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_words[i]) send_sample(directed_words[i]);
      req_valid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_drain();
         case (phase)
            0:       thr = 0;
            1:       thr = 330;
            2:       thr = 511;
            3:       thr = $urandom_range(0, 330);
            default: thr = $urandom_range(0, 511);
         endcase
         write_threshold(thr[THRESH_W-1:0]);
         req_gaps_on = (phase != 1);
         rsp_gaps_on = (phase != 3);
         // stall the output long enough to back the pipeline up to the input
         if (phase == 2) rsp_hold_cycles = LONG_HOLD;
         repeat (GROUPS) begin
            style = $urandom_range(0, 3);
            near  = int'(thr * 1024 / 330) + int'($urandom_range(0, 10)) - 5;
            repeat (2 * AVG_SAMPLES) begin
               case (style)
                  0: s_val = $urandom_range(0, 1) ? 1023 : 0;
                  1: s_val = near + int'($urandom_range(0, 4)) - 2;
                  default: s_val = $urandom_range(0, 1023);
               endcase
               if (s_val < 0) s_val = 0;
               if (s_val > 1023) s_val = 1023;
               s = s_val[SAMPLE_W-1:0];
               send_sample(s);
            end
         end
         req_valid <= 1'b0;
      end

      wait_for_drain();
      if (board.errors == 0 && board.expected_chars.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
